### design/clipped_line_rasterizer_defines.svh
// assertion macros for the clipped line rasterizer checker
// the asserting module provides i_clk and i_rst_n
`ifndef CLIPPED_LINE_RASTERIZER_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_DEFINES_SVH

// check held outside reset
`define CRL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("crl check failed");

// check that also covers the reset cycles
`define CRL_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("crl reset check failed");

`endif

### design/crl_pkg.sv
// shared types and constants of the clipped line rasterizer
// no dependencies
package crl_pkg;

    localparam int CRD_W     = 13;
    localparam int COLOR_W   = 32;
    localparam int PIX_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int               DEF_MAX_DIM = 64;
    localparam logic [CFG_W-1:0] DIM_RESET   = 7'd64;

    localparam int DIFF_W   = CRD_W + 1;
    localparam int DEN_W    = DIFF_W + 1;
    localparam int PROD_W   = 2 * CRD_W + 2;
    localparam int NUM_W    = PROD_W + 1;
    localparam int MAG_W    = NUM_W - 1;
    localparam int DIVCNT_W = $clog2(MAG_W);
    localparam int Q_W      = 16;
    localparam int R_W      = DEN_W + 2;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                    empty;
        logic                    xmajor;
        logic [PIX_W-1:0]        lo;
        logic [PIX_W-1:0]        hi;
        logic [CFG_W-1:0]        mindim;
        logic signed [Q_W-1:0]   q;
        logic signed [R_W-1:0]   r;
        logic [DEN_W-1:0]        den;
        logic signed [R_W-1:0]   step;
        logic [COLOR_W-1:0]      color;
    } t_line;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SETUP,
        F_MULT,
        F_NUM,
        F_DIV,
        F_PUSH
    } t_front_state;

endpackage

### design/crl_front.sv
// front end: takes a line request, orders and clips it, finds the start quotient
// depends on crl_pkg
module crl_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_first_x,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_first_y,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_second_x,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_second_y,
    input  logic [crl_pkg::COLOR_W-1:0]       i_pen_color,
    input  logic [crl_pkg::CFG_W-1:0]         i_width_eff,
    input  logic [crl_pkg::CFG_W-1:0]         i_height_eff,
    output logic                              o_push,
    output crl_pkg::t_line                    o_line,
    input  logic                              i_full
);

    localparam int CRD_W  = crl_pkg::CRD_W;
    localparam int DIFF_W = crl_pkg::DIFF_W;
    localparam int DEN_W  = crl_pkg::DEN_W;
    localparam int PROD_W = crl_pkg::PROD_W;
    localparam int NUM_W  = crl_pkg::NUM_W;
    localparam int MAG_W  = crl_pkg::MAG_W;
    localparam int Q_W    = crl_pkg::Q_W;
    localparam int R_W    = crl_pkg::R_W;
    localparam int PIX_W  = crl_pkg::PIX_W;
    localparam int CFG_W  = crl_pkg::CFG_W;
    localparam int CNT_W  = crl_pkg::DIVCNT_W;

    crl_pkg::t_front_state r_state, n_state;

    logic signed [CRD_W-1:0]       r_x1, r_y1, r_x2, r_y2;
    logic [crl_pkg::COLOR_W-1:0]   r_color;

    logic                          r_xmajor, r_empty, r_diff0;
    logic signed [CRD_W-1:0]       r_ss;
    logic [DIFF_W-1:0]             r_diff;
    logic signed [CRD_W:0]         r_delta;
    logic [CRD_W-1:0]              r_losa;
    logic [PIX_W-1:0]              r_lo, r_hi;
    logic [CFG_W-1:0]              r_mindim;

    logic signed [PROD_W-1:0]      r_p1, r_p2;
    logic                          r_neg;
    logic [MAG_W-1:0]              r_mag, r_quo;
    logic [DEN_W-1:0]              r_rem;
    logic [CNT_W-1:0]              r_cnt;

    // setup: axis choice, ordering and clipping
    logic signed [CRD_W:0]         dx, dy, ea_e, lo_e, lim_e, hi_e, delta_c;
    logic [DIFF_W-1:0]             dxa, dya, diff_c;
    logic                          xmaj_c, first_c, empty_c;
    logic signed [CRD_W-1:0]       sa_c, ss_c, ea_c, es_c;
    logic [CFG_W-1:0]              majdim_c, mindim_c;
    logic [CRD_W-1:0]              losa_c;

    always_comb begin
        dx      = (CRD_W+1)'(r_x2) - (CRD_W+1)'(r_x1);
        dy      = (CRD_W+1)'(r_y2) - (CRD_W+1)'(r_y1);
        dxa     = dx[CRD_W] ? DIFF_W'(-dx) : DIFF_W'(dx);
        dya     = dy[CRD_W] ? DIFF_W'(-dy) : DIFF_W'(dy);
        xmaj_c  = dxa > dya;
        first_c = xmaj_c ? (r_x1 < r_x2) : (r_y1 < r_y2);
        if (xmaj_c) begin
            sa_c     = first_c ? r_x1 : r_x2;
            ss_c     = first_c ? r_y1 : r_y2;
            ea_c     = first_c ? r_x2 : r_x1;
            es_c     = first_c ? r_y2 : r_y1;
            diff_c   = dxa;
            majdim_c = i_width_eff;
            mindim_c = i_height_eff;
        end else begin
            sa_c     = first_c ? r_y1 : r_y2;
            ss_c     = first_c ? r_x1 : r_x2;
            ea_c     = first_c ? r_y2 : r_y1;
            es_c     = first_c ? r_x2 : r_x1;
            diff_c   = dya;
            majdim_c = i_height_eff;
            mindim_c = i_width_eff;
        end
        ea_e    = (CRD_W+1)'(ea_c);
        lo_e    = (sa_c > 0) ? (CRD_W+1)'(sa_c) : '0;
        lim_e   = (CRD_W+1)'(majdim_c) - (CRD_W+1)'(1);
        hi_e    = (ea_e < lim_e) ? ea_e : lim_e;
        empty_c = lo_e > hi_e;
        losa_c  = sa_c[CRD_W-1] ? CRD_W'(-sa_c) : '0;
        delta_c = (CRD_W+1)'(es_c) - (CRD_W+1)'(ss_c);
    end

    // products for the numerator at the first step
    logic signed [PROD_W-1:0] p1_c, p2_c;
    assign p1_c = r_ss * $signed({1'b0, r_diff});
    assign p2_c = $signed({1'b0, r_losa}) * r_delta;

    logic signed [NUM_W-1:0] p1_w, p2_w, num_c;
    logic [MAG_W-1:0]        mag_c;
    assign p1_w  = NUM_W'(r_p1);
    assign p2_w  = NUM_W'(r_p2);
    assign num_c = (p1_w <<< 1) + (p2_w <<< 1) + NUM_W'(r_diff);
    assign mag_c = num_c[NUM_W-1] ? MAG_W'(-num_c) : MAG_W'(num_c);

    // restoring division, one quotient bit a cycle
    logic [DEN_W-1:0] den;
    logic [DEN_W:0]   trial;
    logic             ge;
    assign den   = {r_diff, 1'b0};
    assign trial = {r_rem, r_mag[MAG_W-1]};
    assign ge    = trial >= {1'b0, den};

    // floor quotient and remainder from the magnitude result
    logic signed [Q_W-1:0] qa, q_c;
    logic signed [R_W-1:0] r_c, step_c;
    always_comb begin
        qa = $signed(r_quo[Q_W-1:0]);
        if (r_diff0) begin
            q_c = Q_W'(r_ss);
            r_c = '0;
        end else if (r_neg && (r_rem != '0)) begin
            q_c = -qa - Q_W'(1);
            r_c = R_W'(den) - R_W'(r_rem);
        end else if (r_neg) begin
            q_c = -qa;
            r_c = '0;
        end else begin
            q_c = qa;
            r_c = R_W'(r_rem);
        end
        step_c = R_W'(r_delta) <<< 1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crl_pkg::F_IDLE:  if (i_in_valid) n_state = crl_pkg::F_SETUP;
            crl_pkg::F_SETUP: begin
                n_state = (empty_c || (diff_c == '0)) ? crl_pkg::F_PUSH : crl_pkg::F_MULT;
            end
            crl_pkg::F_MULT:  n_state = crl_pkg::F_NUM;
            crl_pkg::F_NUM:   n_state = crl_pkg::F_DIV;
            crl_pkg::F_DIV:   if (r_cnt == '0) n_state = crl_pkg::F_PUSH;
            crl_pkg::F_PUSH:  if (!i_full) n_state = crl_pkg::F_IDLE;
            default:          n_state = crl_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = r_state != crl_pkg::F_IDLE;
        o_push     = (r_state == crl_pkg::F_PUSH) && !i_full;
    end

    always_comb begin
        o_line.empty  = r_empty;
        o_line.xmajor = r_xmajor;
        o_line.lo     = r_lo;
        o_line.hi     = r_hi;
        o_line.mindim = r_mindim;
        o_line.q      = q_c;
        o_line.r      = r_c;
        o_line.den    = den;
        o_line.step   = step_c;
        o_line.color  = r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crl_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            crl_pkg::F_IDLE: begin
                r_x1    <= i_first_x;
                r_y1    <= i_first_y;
                r_x2    <= i_second_x;
                r_y2    <= i_second_y;
                r_color <= i_pen_color;
            end
            crl_pkg::F_SETUP: begin
                r_xmajor <= xmaj_c;
                r_empty  <= empty_c;
                r_diff0  <= diff_c == '0;
                r_ss     <= ss_c;
                r_diff   <= diff_c;
                r_delta  <= delta_c;
                r_losa   <= losa_c;
                r_lo     <= lo_e[PIX_W-1:0];
                r_hi     <= hi_e[PIX_W-1:0];
                r_mindim <= mindim_c;
            end
            crl_pkg::F_MULT: begin
                r_p1 <= p1_c;
                r_p2 <= p2_c;
            end
            crl_pkg::F_NUM: begin
                r_neg <= num_c[NUM_W-1];
                r_mag <= mag_c;
                r_rem <= '0;
                r_cnt <= CNT_W'(MAG_W - 1);
            end
            crl_pkg::F_DIV: begin
                r_rem <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
                r_quo <= {r_quo[MAG_W-2:0], ge};
                r_mag <= {r_mag[MAG_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            crl_pkg::F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

endmodule

### design/crl_queue.sv
// short queue of prepared lines between front and back end
// depends on crl_pkg
module crl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crl_pkg::t_line  i_line,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_avail,
    output crl_pkg::t_line  o_line
);

    localparam int DEPTH = crl_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    crl_pkg::t_line   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_avail = r_count != '0;
    assign o_line  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### design/crl_back.sv
// back end: walks the major axis and emits one pixel word a cycle while the output is not stalled
// depends on crl_pkg
module crl_back #(
    parameter int MAX_DIM = crl_pkg::DEF_MAX_DIM
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_avail,
    input  crl_pkg::t_line               i_line,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [crl_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [crl_pkg::PIX_W-1:0]    o_pixel_y,
    output logic [crl_pkg::COLOR_W-1:0]  o_write_color,
    output logic                         o_inside_res,
    output logic                         o_last_step
);

    localparam int MW    = $clog2(MAX_DIM);
    localparam int Q_W   = crl_pkg::Q_W;
    localparam int R_W   = crl_pkg::R_W;
    localparam int PIX_W = crl_pkg::PIX_W;

    logic                  r_busy, r_out_valid;
    crl_pkg::t_line        r_line;
    logic [MW-1:0]         r_m;
    logic signed [Q_W-1:0] r_q;
    logic signed [R_W-1:0] r_r;

    logic [PIX_W-1:0]             r_px, r_py;
    logic [crl_pkg::COLOR_W-1:0]  r_col;
    logic                         r_ins, r_last;

    logic                  emit, last_c, ins_c;
    logic signed [Q_W-1:0] mt;
    logic [Q_W-1:0]        mt_u;
    logic [PIX_W-1:0]      mn, mj;
    logic signed [R_W-1:0] s_c, den_s;

    assign o_pop = !r_busy && i_avail;
    assign emit  = r_busy && (!r_out_valid || !i_out_stall);

    always_comb begin
        last_c = r_line.empty || (r_m == r_line.hi[MW-1:0]);
        mt     = (r_q[Q_W-1] && (r_r != '0)) ? r_q + Q_W'(1) : r_q;
        mt_u   = mt;
        ins_c  = !mt[Q_W-1] && (mt_u < Q_W'(r_line.mindim));
        mn     = ins_c ? mt_u[PIX_W-1:0] : '0;
        mj     = PIX_W'(r_m);
        s_c    = r_r + r_line.step;
        den_s  = $signed(R_W'(r_line.den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last_c) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_line <= i_line;
            r_m    <= i_line.lo[MW-1:0];
            r_q    <= i_line.q;
            r_r    <= i_line.r;
        end else if (emit) begin
            r_m <= r_m + MW'(1);
            priority if ((r_line.den != '0) && (s_c >= den_s)) begin
                r_r <= s_c - den_s;
                r_q <= r_q + Q_W'(1);
            end else if (s_c < 0) begin
                r_r <= s_c + den_s;
                r_q <= r_q - Q_W'(1);
            end else begin
                r_r <= s_c;
            end
        end
        if (emit) begin
            if (r_line.empty) begin
                r_px   <= '0;
                r_py   <= '0;
                r_col  <= '0;
                r_ins  <= 1'b0;
                r_last <= 1'b1;
            end else begin
                r_px   <= r_line.xmajor ? mj : mn;
                r_py   <= r_line.xmajor ? mn : mj;
                r_col  <= r_line.color;
                r_ins  <= ins_c;
                r_last <= last_c;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_write_color = r_col;
    assign o_inside_res  = r_ins;
    assign o_last_step   = r_last;

endmodule

### design/clipped_line_rasterizer.sv
// clipped line rasterizer: a taken request passes the front end and the line queue,
// then one pixel word a cycle while the output is not stalled, along the clipped
// major axis, up to MAX_DIM words; the front end finds the start quotient by a
// bit-serial division, which empty and single-point lines skip
// synchronous active-low reset: queue empty, no word pending, both sizes set to 64
module clipped_line_rasterizer #(
    parameter int MAX_DIM = crl_pkg::DEF_MAX_DIM
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [crl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crl_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_first_x,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_first_y,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_second_x,
    input  logic signed [crl_pkg::CRD_W-1:0]  i_second_y,
    input  logic [crl_pkg::COLOR_W-1:0]       i_pen_color,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [crl_pkg::PIX_W-1:0]         o_pixel_x,
    output logic [crl_pkg::PIX_W-1:0]         o_pixel_y,
    output logic [crl_pkg::COLOR_W-1:0]       o_write_color,
    output logic                              o_inside_res,
    output logic                              o_last_step
);

    localparam int CFG_W = crl_pkg::CFG_W;

    logic [CFG_W-1:0] r_width, r_height;
    logic [CFG_W-1:0] width_eff, height_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= crl_pkg::DIM_RESET;
            r_height <= crl_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crl_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                crl_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        priority if (r_width == '0)                 width_eff = CFG_W'(1);
        else if (r_width > CFG_W'(MAX_DIM))         width_eff = CFG_W'(MAX_DIM);
        else                                        width_eff = r_width;
        priority if (r_height == '0)                height_eff = CFG_W'(1);
        else if (r_height > CFG_W'(MAX_DIM))        height_eff = CFG_W'(MAX_DIM);
        else                                        height_eff = r_height;
    end

    logic           push, full, pop, avail;
    crl_pkg::t_line front_line, queue_line;

    crl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_pen_color  (i_pen_color),
        .i_width_eff  (width_eff),
        .i_height_eff (height_eff),
        .o_push       (push),
        .o_line       (front_line),
        .i_full       (full)
    );

    crl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_line  (front_line),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_line  (queue_line)
    );

    crl_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (avail),
        .i_line        (queue_line),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_write_color (o_write_color),
        .o_inside_res  (o_inside_res),
        .o_last_step   (o_last_step)
    );

endmodule

### design/crl_checker.sv
// port-level checks for the clipped line rasterizer, bound to the top level
// depends on crl_pkg and clipped_line_rasterizer_defines.svh
`include "clipped_line_rasterizer_defines.svh"

module crl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [crl_pkg::PIX_W-1:0]         o_pixel_x,
    input logic [crl_pkg::PIX_W-1:0]         o_pixel_y,
    input logic [crl_pkg::COLOR_W-1:0]       o_write_color,
    input logic                              o_inside_res,
    input logic                              o_last_step
);

    logic [2*crl_pkg::PIX_W+crl_pkg::COLOR_W+1:0] out_word;

    assign out_word = {o_pixel_x, o_pixel_y, o_write_color, o_inside_res, o_last_step};

    // a stalled word holds
    `CRL_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(out_word))

    // a pixel outside the image has its minor coordinate cleared
    `CRL_ASSERT(a_outside_zero, o_out_valid && !o_inside_res |-> o_pixel_x == '0 || o_pixel_y == '0)

    // the input is stalled in the cycle after a request is taken
    `CRL_ASSERT(a_busy_after_take, i_in_valid && !o_in_stall |=> o_in_stall)

    // reset leaves no word pending and the input open
    `CRL_ASSERT_RST(a_reset_state, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind clipped_line_rasterizer crl_checker u_crl_checker (.*);

### tb/sv/clipped_line_rasterizer_tb.sv
// self-checking testbench for clipped_line_rasterizer: line requests in, pixel words out
// predicts every pixel word in exact integer arithmetic and checks it field by field
// depends on crl_pkg and the clipped_line_rasterizer rtl
module clipped_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CRD_W      = crl_pkg::CRD_W;
    localparam int COLOR_W    = crl_pkg::COLOR_W;
    localparam int PIX_W      = crl_pkg::PIX_W;
    localparam int CFG_W      = crl_pkg::CFG_W;
    localparam int CFG_IDX_W  = crl_pkg::CFG_IDX_W;
    localparam int MAX_PIXELS = crl_pkg::DEF_MAX_DIM;

    typedef logic signed [CRD_W-1:0] t_coord;

    typedef struct {
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [COLOR_W-1:0] color;
        logic               ins;
        logic               last_step;
    } t_pixel_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = crl_pkg::REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_coord             i_first_x = '0;
    t_coord             i_first_y = '0;
    t_coord             i_second_x = '0;
    t_coord             i_second_y = '0;
    logic [COLOR_W-1:0] i_pen_color = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [PIX_W-1:0]   o_pixel_x;
    logic [PIX_W-1:0]   o_pixel_y;
    logic [COLOR_W-1:0] o_write_color;
    logic               o_inside_res;
    logic               o_last_step;

    t_pixel_word pending_pixels[$];
    logic [CFG_W-1:0] dim_width = crl_pkg::DIM_RESET;
    logic [CFG_W-1:0] dim_height = crl_pkg::DIM_RESET;

    int mismatches = 0;
    int lines_sent = 0;
    int pixels_checked = 0;
    int settings_used = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int unsigned hold_left = 0;
    int unsigned stall_cycle = 0;
    int stall_mode = 0;

    clipped_line_rasterizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_first_x     (i_first_x),
        .i_first_y     (i_first_y),
        .i_second_x    (i_second_x),
        .i_second_y    (i_second_y),
        .i_pen_color   (i_pen_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_write_color (o_write_color),
        .o_inside_res  (o_inside_res),
        .o_last_step   (o_last_step)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint eff_dim(input logic [CFG_W-1:0] v);
        if (v < 1) return 1;
        if (v > MAX_PIXELS) return MAX_PIXELS;
        return longint'(v);
    endfunction

    // expected pixel words of one line under the current image size
    function automatic void plot_line(input t_coord fx, input t_coord fy, input t_coord sx,
                                      input t_coord sy, input logic [COLOR_W-1:0] col);
        longint x1, y1, x2, y2, w, h, dxa, dya;
        longint sa, ss, ea, es, diff, majdim, mindim, lo, hi, delta, m, minor, mn;
        bit xmajor, ins;
        int n;
        t_pixel_word pw;
        x1 = fx;
        y1 = fy;
        x2 = sx;
        y2 = sy;
        w = eff_dim(dim_width);
        h = eff_dim(dim_height);
        dxa = (x1 > x2) ? x1 - x2 : x2 - x1;
        dya = (y1 > y2) ? y1 - y2 : y2 - y1;
        xmajor = dxa > dya;
        if (xmajor) begin
            sa = (x1 < x2) ? x1 : x2;
            ss = (x1 < x2) ? y1 : y2;
            ea = (x1 < x2) ? x2 : x1;
            es = (x1 < x2) ? y2 : y1;
            diff = dxa;
            majdim = w;
            mindim = h;
        end else begin
            sa = (y1 < y2) ? y1 : y2;
            ss = (y1 < y2) ? x1 : x2;
            ea = (y1 < y2) ? y2 : y1;
            es = (y1 < y2) ? x2 : x1;
            diff = dya;
            majdim = h;
            mindim = w;
        end
        lo = (sa > 0) ? sa : 0;
        hi = (ea < majdim - 1) ? ea : majdim - 1;
        delta = es - ss;
        if (lo > hi) begin
            pw = '{px: '0, py: '0, color: '0, ins: 1'b0, last_step: 1'b1};
            pending_pixels.push_back(pw);
            return;
        end
        n = 0;
        for (m = lo; m <= hi && n < MAX_PIXELS; m++) begin
            if (diff == 0)
                minor = ss;
            else
                minor = (2 * ss * diff + 2 * (m - sa) * delta + diff) / (2 * diff);
            ins = (minor >= 0) && (minor < mindim);
            mn = ins ? minor : 0;
            pw.px = xmajor ? m[PIX_W-1:0] : mn[PIX_W-1:0];
            pw.py = xmajor ? mn[PIX_W-1:0] : m[PIX_W-1:0];
            pw.color = col;
            pw.ins = ins;
            pw.last_step = (m == hi);
            pending_pixels.push_back(pw);
            n++;
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel word, expected none, got x=%0d y=%0d",
                         $time, o_pixel_x, o_pixel_y);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.px, o_pixel_x);
                check_field("pixel_y", want.py, o_pixel_y);
                check_field("write_color", want.color, o_write_color);
                check_field("inside_res", want.ins, o_inside_res);
                check_field("last_step", want.last_step, o_last_step);
                pixels_checked++;
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 97 == 0)
            stall_mode = $urandom_range(3);
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(3) == 0);
                2: i_out_stall <= ((stall_cycle % 7) < 3);
                default: i_out_stall <= ($urandom_range(9) < 7);
            endcase
        end
    end

    task automatic send_line(input t_coord fx, input t_coord fy, input t_coord sx,
                             input t_coord sy, input logic [COLOR_W-1:0] col);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(8, 1);
            gap = gaps_on ? $urandom_range(6) : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_first_x <= fx;
        i_first_y <= fy;
        i_second_x <= sx;
        i_second_y <= sy;
        i_pen_color <= col;
        do @(posedge i_clk); while (o_in_stall);
        plot_line(fx, fy, sx, sy, col);
        lines_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= crl_pkg::REG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        dim_width = w;
        i_cfg_index <= crl_pkg::REG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        dim_height = h;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    function automatic t_coord pick_coord(input int span);
        case ($urandom_range(9))
            0, 1: return t_coord'($urandom);
            2, 3, 4: return t_coord'(int'($urandom_range(span + 39)) - 20);
            default: return t_coord'(int'($urandom_range(span - 1)));
        endcase
    endfunction

    task automatic test_directed_lines();
        send_line(5, 7, 5, 7, 32'h1234_5678);
        send_line(-3, 10, -3, 10, 32'hFFFF_FFFF);
        send_line(-5, -5, -5, -5, 32'h0000_0000);
        send_line(0, 3, 63, 3, 32'hA5A5_5A5A);
        send_line(63, 60, 0, 0, 32'h0F0F_F0F0);
        send_line(10, 0, 10, 63, 32'h8000_0001);
        send_line(0, 0, 63, 63, 32'h7FFF_FFFE);
        send_line(-4096, -4096, 4095, 4095, 32'hFFFF_FFFF);
        send_line(4095, -4096, -4096, 4095, 32'h0000_0000);
        send_line(-100, 5, -50, 6, 32'hDEAD_BEEF);
        send_line(100, 5, 200, 5, 32'hCAFE_F00D);
        send_line(0, -100, 4000, 100, 32'h1111_2222);
        send_line(0, 0, 4, -1, 32'h3333_4444);
        send_line(20, -4096, -20, 4095, 32'h5555_6666);
        send_line(-4096, 30, 4095, 31, 32'h7777_8888);
        send_line(62, 1, 1, 62, 32'h9999_AAAA);
        send_line(3, 2, 4, 40, 32'hBBBB_CCCC);
    endtask

    task automatic test_size_extremes();
        set_dims(1, 1);
        send_line(0, 0, 0, 0, 32'h0102_0304);
        send_line(-2, 0, 5, 1, 32'h0506_0708);
        set_dims(0, 127);
        send_line(0, 0, 3, 70, 32'h090A_0B0C);
        set_dims(127, 0);
        send_line(-10, 0, 80, 2, 32'h0D0E_0F10);
        set_dims(64, 1);
        send_line(0, 0, 63, 40, 32'h1112_1314);
        send_line(30, -1, 31, 1, 32'h1516_1718);
    endtask

    task automatic test_backpressure();
        set_dims(64, 64);
        gaps_on = 1'b0;
        hold_left = 400;
        for (int k = 0; k < 8; k++)
            send_line(0, t_coord'(k), 40, t_coord'(k + 5), $urandom);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_lines();
        logic [CFG_W-1:0] w, h;
        t_coord fx, fy, sx, sy;
        int span_x, span_y;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin w = 64; h = 64; end
                1: begin
                    w = CFG_W'($urandom_range(64, 1));
                    h = CFG_W'($urandom_range(64, 1));
                end
                2: begin w = 1; h = 64; end
                3: begin w = 0; h = 127; end
                default: begin
                    w = CFG_W'($urandom_range(127));
                    h = CFG_W'($urandom_range(127));
                end
            endcase
            set_dims(w, h);
            gaps_on = (phase != 2);
            span_x = int'(eff_dim(w));
            span_y = int'(eff_dim(h));
            for (int k = 0; k < 46; k++) begin
                fx = pick_coord(span_x);
                fy = pick_coord(span_y);
                if ($urandom_range(3) == 0) begin
                    sx = fx + t_coord'(int'($urandom_range(6)) - 3);
                    sy = fy + t_coord'(int'($urandom_range(6)) - 3);
                end else begin
                    sx = pick_coord(span_x);
                    sy = pick_coord(span_y);
                end
                send_line(fx, fy, sx, sy, $urandom);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        int guard;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed_lines();
        test_size_extremes();
        test_backpressure();
        test_random_lines();
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d pixel words expected, 0 received", $time, pending_pixels.size());
            mismatches++;
        end
        $display("covered %0d line requests and %0d pixel words under %0d image sizes,",
                 lines_sent, pixels_checked, settings_used);
        $display("including empty, single-point, clipped and stalled-input cases");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
